// File: design/stw_pkg.sv
// Shared types and constants for the stopwatch and countdown timer.
package stw_pkg;

   typedef enum logic [2:0] {
      MODE_MENU    = 3'd0,
      MODE_SW_IDLE = 3'd1,
      MODE_SW_RUN  = 3'd2,
      MODE_SW_STOP = 3'd3,
      MODE_CD_SET  = 3'd4,
      MODE_CD_RUN  = 3'd5,
      MODE_CD_DONE = 3'd6
   } mode_type;

   typedef enum logic {
      CSR_REDRAW_INTERVAL = 1'b0,
      CSR_FLASH_PERIOD    = 1'b1
   } csr_index_type;

   localparam logic [15:0] REDRAW_INTERVAL_RESET = 16'd100;
   localparam logic [15:0] FLASH_PERIOD_RESET    = 16'd500;

   localparam logic [6:0]  MINUTES_MIN   = 7'd1;
   localparam logic [6:0]  MINUTES_MAX   = 7'd99;
   localparam logic [6:0]  MINUTES_RESET = 7'd5;
   localparam logic [22:0] MS_PER_MINUTE = 23'd60000;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        press_back;
      logic        press_confirm;
      logic        press_up;
      logic        press_down;
      logic        press_next;
      logic        press_previous;
   } poll_type;

   typedef struct packed {
      logic [15:0] redraw_interval_ms;
      logic [15:0] flash_period_ms;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic        selected_mode;
      logic [31:0] elapsed_ms;
      logic [22:0] remaining_ms;
      logic [6:0]  minutes_setting;
      logic [4:0]  lap_count;
      logic        lap_recorded;
      logic        flash_on;
      logic        redraw;
      logic        leave;
   } result_type;

endpackage

// File: design/stw_csr.sv
// Configuration registers: redraw interval and flash period.
module stw_csr
   import stw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   logic [15:0] redraw_interval_ff;
   logic [15:0] redraw_interval_in;
   logic [15:0] flash_period_ff;
   logic [15:0] flash_period_in;
   logic        write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      redraw_interval_in = redraw_interval_ff;
      flash_period_in    = flash_period_ff;
      if (write) begin
         case (csr_index_type'(csr_index))
            CSR_REDRAW_INTERVAL: redraw_interval_in = csr_data;
            CSR_FLASH_PERIOD:    flash_period_in    = csr_data;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         redraw_interval_ff <= REDRAW_INTERVAL_RESET;
         flash_period_ff    <= FLASH_PERIOD_RESET;
      end else begin
         redraw_interval_ff <= redraw_interval_in;
         flash_period_ff    <= flash_period_in;
      end
   end

   assign cfg.redraw_interval_ms = redraw_interval_ff;
   assign cfg.flash_period_ms    = flash_period_ff;

endmodule

// File: design/stw_engine.sv
// Mode machine and timer state: one poll is evaluated per enabled cycle.
module stw_engine
   import stw_pkg::*;
#(
   parameter int LAP_LIMIT = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  poll_type   poll,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int LAP_W = $clog2(LAP_LIMIT + 1);
   localparam logic [LAP_W-1:0] LAP_MAX = LAP_W'(LAP_LIMIT);

   mode_type         mode_ff, mode_in;
   logic             choice_ff, choice_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [31:0]      paused_ff, paused_in;
   logic [31:0]      start_ff, start_in;
   logic [LAP_W-1:0] laps_ff, laps_in;
   logic [6:0]       minutes_ff, minutes_in;
   logic [22:0]      remaining_ff, remaining_in;
   logic [31:0]      last_tick_ff, last_tick_in;
   logic             flash_ff, flash_in;
   logic [31:0]      flash_stamp_ff, flash_stamp_in;
   logic [31:0]      last_redraw_ff, last_redraw_in;

   logic [31:0] run_elapsed;
   logic        redraw_due;
   logic [31:0] cd_step;
   logic        cd_expire;
   logic        flash_due;
   logic [6:0]  minutes_up;
   logic [6:0]  minutes_down;
   logic [22:0] cd_load;
   logic        lap_room;
   logic        redraw;
   logic        lap;
   logic        leave;

   assign run_elapsed  = paused_ff + (poll.now_ms - start_ff);
   assign redraw_due   = (poll.now_ms - last_redraw_ff) >= {16'd0, cfg.redraw_interval_ms};
   assign cd_step      = poll.now_ms - last_tick_ff;
   assign cd_expire    = cd_step >= {9'd0, remaining_ff};
   assign flash_due    = (poll.now_ms - flash_stamp_ff) >= {16'd0, cfg.flash_period_ms};
   assign minutes_up   = (poll.press_up && (minutes_ff < MINUTES_MAX)) ?
                         minutes_ff + 7'd1 : minutes_ff;
   assign minutes_down = (poll.press_down && (minutes_up > MINUTES_MIN)) ?
                         minutes_up - 7'd1 : minutes_up;
   assign cd_load      = 23'(minutes_down) * MS_PER_MINUTE;
   assign lap_room     = laps_ff < LAP_MAX;

   // next state
   always_comb begin
      mode_in        = mode_ff;
      choice_in      = choice_ff;
      elapsed_in     = elapsed_ff;
      paused_in      = paused_ff;
      start_in       = start_ff;
      laps_in        = laps_ff;
      minutes_in     = minutes_ff;
      remaining_in   = remaining_ff;
      last_tick_in   = last_tick_ff;
      flash_in       = flash_ff;
      flash_stamp_in = flash_stamp_ff;
      last_redraw_in = last_redraw_ff;
      case (mode_ff)
         MODE_MENU: begin
            if (!poll.press_back) begin
               choice_in = choice_ff ^ poll.press_next ^ poll.press_previous;
               if (poll.press_confirm) begin
                  if (!choice_in) begin
                     mode_in    = MODE_SW_IDLE;
                     elapsed_in = '0;
                     paused_in  = '0;
                     laps_in    = '0;
                  end else begin
                     mode_in = MODE_CD_SET;
                  end
               end
            end
         end
         MODE_SW_IDLE, MODE_SW_RUN, MODE_SW_STOP: begin
            if (mode_ff == MODE_SW_RUN) begin
               elapsed_in = run_elapsed;
               if (redraw_due) begin
                  last_redraw_in = poll.now_ms;
               end
            end
            if (poll.press_confirm) begin
               if (mode_ff == MODE_SW_IDLE) begin
                  start_in  = poll.now_ms;
                  paused_in = '0;
                  mode_in   = MODE_SW_RUN;
               end else if (mode_ff == MODE_SW_RUN) begin
                  if (lap_room) begin
                     laps_in = laps_ff + LAP_W'(1);
                  end
               end else begin
                  start_in   = poll.now_ms;
                  paused_in  = '0;
                  elapsed_in = '0;
                  laps_in    = '0;
                  mode_in    = MODE_SW_RUN;
               end
            end else if (poll.press_back) begin
               if (mode_ff == MODE_SW_RUN) begin
                  paused_in = run_elapsed;
                  mode_in   = MODE_SW_STOP;
               end else begin
                  mode_in = MODE_MENU;
               end
            end
         end
         MODE_CD_SET: begin
            if (poll.press_back) begin
               mode_in = MODE_MENU;
            end else begin
               minutes_in = minutes_down;
               if (poll.press_confirm) begin
                  remaining_in = cd_load;
                  last_tick_in = poll.now_ms;
                  mode_in      = MODE_CD_RUN;
               end
            end
         end
         MODE_CD_RUN: begin
            last_tick_in = poll.now_ms;
            if (cd_expire) begin
               remaining_in   = '0;
               mode_in        = MODE_CD_DONE;
               flash_in       = 1'b1;
               flash_stamp_in = poll.now_ms;
            end else begin
               remaining_in = remaining_ff - cd_step[22:0];
               if (redraw_due) begin
                  last_redraw_in = poll.now_ms;
               end
            end
            if (poll.press_back) begin
               mode_in = MODE_CD_SET;
            end
         end
         MODE_CD_DONE: begin
            if (flash_due) begin
               flash_in       = ~flash_ff;
               flash_stamp_in = poll.now_ms;
            end
            if (poll.press_back || poll.press_confirm) begin
               mode_in = MODE_CD_SET;
            end
         end
         default: ;
      endcase
   end

   // per-poll flags
   always_comb begin
      redraw = 1'b0;
      lap    = 1'b0;
      leave  = 1'b0;
      case (mode_ff)
         MODE_MENU: begin
            leave  = poll.press_back;
            redraw = ~poll.press_back &
                     (poll.press_next | poll.press_previous | poll.press_confirm);
         end
         MODE_SW_IDLE, MODE_SW_RUN, MODE_SW_STOP: begin
            redraw = ((mode_ff == MODE_SW_RUN) && redraw_due) ||
                     poll.press_confirm || poll.press_back;
            lap    = (mode_ff == MODE_SW_RUN) && poll.press_confirm && lap_room;
         end
         MODE_CD_SET: begin
            redraw = poll.press_back | poll.press_up | poll.press_down | poll.press_confirm;
         end
         MODE_CD_RUN: begin
            redraw = cd_expire | redraw_due | poll.press_back;
         end
         MODE_CD_DONE: begin
            redraw = flash_due | poll.press_back | poll.press_confirm;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_MENU;
         choice_ff      <= 1'b0;
         elapsed_ff     <= '0;
         paused_ff      <= '0;
         laps_ff        <= '0;
         minutes_ff     <= MINUTES_RESET;
         remaining_ff   <= '0;
         flash_ff       <= 1'b0;
         last_redraw_ff <= '0;
      end else if (enable) begin
         mode_ff        <= mode_in;
         choice_ff      <= choice_in;
         elapsed_ff     <= elapsed_in;
         paused_ff      <= paused_in;
         laps_ff        <= laps_in;
         minutes_ff     <= minutes_in;
         remaining_ff   <= remaining_in;
         flash_ff       <= flash_in;
         last_redraw_ff <= last_redraw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         start_ff       <= start_in;
         last_tick_ff   <= last_tick_in;
         flash_stamp_ff <= flash_stamp_in;
      end
   end

   assign result.mode            = mode_in;
   assign result.selected_mode   = choice_in;
   assign result.elapsed_ms      = elapsed_in;
   assign result.remaining_ms    = remaining_in;
   assign result.minutes_setting = minutes_in;
   assign result.lap_count       = 5'(laps_in);
   assign result.lap_recorded    = lap;
   assign result.flash_on        = (mode_in == MODE_CD_DONE) ? flash_in : 1'b0;
   assign result.redraw          = redraw;
   assign result.leave           = leave;

   assert property (@(posedge clock) disable iff (reset)
      laps_ff <= LAP_MAX)
      else $error("lap counter above limit");

   assert property (@(posedge clock) disable iff (reset)
      (minutes_ff >= MINUTES_MIN) && (minutes_ff <= MINUTES_MAX))
      else $error("minutes setting out of range");

   assert property (@(posedge clock) disable iff (reset)
      enable && lap |=> laps_ff == $past(laps_ff) + LAP_W'(1))
      else $error("lap recorded without count advance");

endmodule

// File: design/stopwatch_countdown_timer.sv
// Stopwatch and countdown timer top level: poll and result registers around the engine.
//
// Usage: each poll transaction on the req_ channel carries the current
// millisecond time and the button presses seen since the previous poll. The
// block answers every poll with exactly one result transaction on the rsp_
// channel: mode, selected choice, stopwatch and countdown times, minutes
// setting, lap count and the lap, flash, redraw and leave flags.
// A transaction moves at a rising edge where valid is high and stall is low.
// A poll is held in the poll register, evaluated by the engine and captured
// in the result register, which offers it on rsp_. One poll per cycle while
// rsp_stall is low: the poll register feeds a single combinational pass into
// the result register. When rsp_stall holds, the result register keeps its
// transaction, one more poll waits in the poll register, and req_stall rises.
// The csr_ channel writes the redraw interval (index 0) and flash period
// (index 1); csr_ready is always high. Write only while no poll is in flight.
// Reset (synchronous, active high) returns to mode select with cleared
// times, five countdown minutes and the default interval and period.
module stopwatch_countdown_timer
   import stw_pkg::*;
#(
   parameter int LAP_LIMIT = 16
)
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_now_ms,
   input  logic        req_press_back,
   input  logic        req_press_confirm,
   input  logic        req_press_up,
   input  logic        req_press_down,
   input  logic        req_press_next,
   input  logic        req_press_previous,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic        rsp_selected_mode,
   output logic [31:0] rsp_elapsed_ms,
   output logic [22:0] rsp_remaining_ms,
   output logic [6:0]  rsp_minutes_setting,
   output logic [4:0]  rsp_lap_count,
   output logic        rsp_lap_recorded,
   output logic        rsp_flash_on,
   output logic        rsp_redraw,
   output logic        rsp_leave,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic       in_valid_ff, in_valid_in;
   poll_type   poll_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   result_type result;
   cfg_type    cfg;
   logic       req_take;
   logic       advance;

   assign advance     = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall   = in_valid_ff & ~advance;
   assign req_take    = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         poll_ff <= '{now_ms:         req_now_ms,
                      press_back:     req_press_back,
                      press_confirm:  req_press_confirm,
                      press_up:       req_press_up,
                      press_down:     req_press_down,
                      press_next:     req_press_next,
                      press_previous: req_press_previous};
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   stw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   stw_engine #(
      .LAP_LIMIT (LAP_LIMIT)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .poll   (poll_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_mode            = result_ff.mode;
   assign rsp_selected_mode   = result_ff.selected_mode;
   assign rsp_elapsed_ms      = result_ff.elapsed_ms;
   assign rsp_remaining_ms    = result_ff.remaining_ms;
   assign rsp_minutes_setting = result_ff.minutes_setting;
   assign rsp_lap_count       = result_ff.lap_count;
   assign rsp_lap_recorded    = result_ff.lap_recorded;
   assign rsp_flash_on        = result_ff.flash_on;
   assign rsp_redraw          = result_ff.redraw;
   assign rsp_leave           = result_ff.leave;

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("poll stalled without a blocked result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_leave |-> rsp_mode == MODE_MENU)
      else $error("leave outside mode select");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flash_on |-> rsp_mode == MODE_CD_DONE)
      else $error("flash outside countdown done");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lap_recorded |-> rsp_redraw && rsp_mode == MODE_SW_RUN)
      else $error("lap recorded outside running stopwatch");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("evaluated poll lost");

endmodule
